@@ sv/stmqd_pkg.sv @@
// Shared types and constants of the stepper move queue dispatcher.
package stmqd_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_XY_STEPS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_Z_STEPS  = 2'd1;

  localparam logic [7:0] XY_STEPS_RESET = 8'd25;
  localparam logic [7:0] Z_STEPS_RESET  = 8'd9;

  // Command codes.
  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // Move kinds.
  localparam logic [3:0] KIND_LEFT        = 4'd0;
  localparam logic [3:0] KIND_RIGHT       = 4'd1;
  localparam logic [3:0] KIND_UP          = 4'd2;
  localparam logic [3:0] KIND_DOWN        = 4'd3;
  localparam logic [3:0] KIND_CW          = 4'd4;
  localparam logic [3:0] KIND_ACW         = 4'd5;
  localparam logic [3:0] KIND_RIGHT_CW    = 4'd6;
  localparam logic [3:0] KIND_LEFT_CW     = 4'd7;
  localparam logic [3:0] KIND_RIGHT_ACW   = 4'd8;
  localparam logic [3:0] KIND_LEFT_ACW    = 4'd9;
  localparam logic [3:0] KIND_UP_CW       = 4'd10;
  localparam logic [3:0] KIND_DOWN_CW     = 4'd11;
  localparam logic [3:0] KIND_UP_ACW      = 4'd12;
  localparam logic [3:0] KIND_DOWN_ACW    = 4'd13;
  localparam logic [3:0] KIND_SUBMM_DOWN  = 4'd14;
  localparam logic [3:0] KIND_SUBMM_UP    = 4'd15;

  // Z step clock compare values.
  localparam logic [9:0] Z_PERIOD_RESET = 10'd249;
  localparam logic [9:0] Z_PERIOD_DIAG  = 10'd640;

  // One queued move.
  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] xy_dist;
    logic [7:0] z_dist;
  } move_t;

  // Status that travels with an item down the pipeline.
  typedef struct packed {
    logic       full;
    logic       started;
    logic       x_dir;
    logic       y_dir;
    logic       z_dir;
    logic       run_xy;
    logic       run_z;
    logic [9:0] z_period;
  } status_t;

endpackage

@@ sv/stepper_move_queue_dispatcher_core.sv @@
// Stepper move queue dispatcher: move ring, direction state and duration arithmetic.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+---------------------------------------------
//   input    | in_valid_i / in_stall_o   | command, move_kind, xy_distance, z_distance
//   output   | out_valid_o / out_stall_i | queue_full .. duration_saturated
//   config   | cfg_we_i                  | cfg_index_i, cfg_wdata_i
//
// One item per cycle while the output is not stalled; each item passes through the four
// register stages in order: input, ring access with registered store read, step product, result.
// Reset empties the ring, clears the direction bits and sets the Z period to 249.
// A stalled output holds its result; the input is stalled only when every stage is full.
module stepper_move_queue_dispatcher_core
  import stmqd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                command_i,
  input  logic [3:0]          move_kind_i,
  input  logic [7:0]          xy_distance_i,
  input  logic [7:0]          z_distance_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                queue_full_o,
  output logic                started_o,
  output logic                x_direction_o,
  output logic                y_direction_o,
  output logic                z_direction_o,
  output logic                run_xy_clocks_o,
  output logic                run_z_clock_o,
  output logic [9:0]          z_step_period_o,
  output logic [15:0]         oneshot_compare_o,
  output logic                duration_saturated_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);

  // Stage advance chain; a stage loads when it is empty or the one after it moves on.
  logic adv1, adv2, adv3, adv_out;

  // Configuration.
  logic [7:0] xy_steps_q, z_steps_q;

  // Stage 1: input register.
  logic       s1_v_q;
  logic       s1_cmd_q;
  move_t      s1_move_q;

  // Ring state.
  move_t           mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] rd_ptr_q, wr_ptr_q;
  logic [PtrW-1:0] rd_next, wr_next;
  logic            ring_full, ring_empty;
  logic            s1_push_ok, s1_pop_ok;

  // Stage 2: ring outcome and the popped move.
  logic  s2_v_q, s2_full_q, s2_started_q;
  move_t s2_entry_q;

  // Retained state.
  logic       x_dir_q, y_dir_q, z_dir_q;
  logic       x_dir_d, y_dir_d, z_dir_d;
  logic [9:0] z_period_q, z_period_d;
  logic       run_xy_d, run_z_d, tenths_d, use_z_d;
  logic [7:0] dist_d, steps_d;
  logic [15:0] prod_d;

  // Stage 3: status and product.
  logic        s3_v_q;
  status_t     s3_stat_q;
  logic [15:0] s3_prod_q;
  logic        s3_tenths_q;

  logic [22:0] x125;
  logic [20:0] x25;
  logic [22:0] plain_full;
  logic [20:0] tenths_full;
  logic [20:0] dur;
  logic [15:0] cmp_d;
  logic        sat_d;

  // Output register.
  logic        out_v_q;
  status_t     out_stat_q;
  logic [15:0] out_cmp_q;
  logic        out_sat_q;

  assign adv_out    = !out_v_q || !out_stall_i;
  assign adv3       = !s3_v_q || adv_out;
  assign adv2       = !s2_v_q || adv3;
  assign adv1       = !s1_v_q || adv2;
  assign in_stall_o = !adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xy_steps_q <= XY_STEPS_RESET;
      z_steps_q  <= Z_STEPS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_XY_STEPS: xy_steps_q <= cfg_wdata_i;
        CFG_Z_STEPS:  z_steps_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage 1.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv1) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      s1_cmd_q  <= command_i;
      s1_move_q <= '{kind: move_kind_i, xy_dist: xy_distance_i, z_dist: z_distance_i};
    end
  end

  // Ring pointers; one slot always stays free.
  assign rd_next    = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
  assign wr_next    = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
  assign ring_full  = (wr_next == rd_ptr_q);
  assign ring_empty = (rd_ptr_q == wr_ptr_q);
  assign s1_push_ok = s1_v_q && adv2 && (s1_cmd_q == CMD_PUSH) && !ring_full;
  assign s1_pop_ok  = s1_v_q && adv2 && (s1_cmd_q == CMD_START) && !ring_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      s2_v_q   <= 1'b0;
    end else begin
      if (s1_push_ok) begin
        wr_ptr_q <= wr_next;
      end
      if (s1_pop_ok) begin
        rd_ptr_q <= rd_next;
      end
      if (adv2) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_push_ok) begin
      mem_q[wr_ptr_q] <= s1_move_q;
    end
  end

  // The store is read at the head every time stage 2 loads; only a start uses the data.
  always_ff @(posedge clk_i) begin
    if (adv2) begin
      s2_entry_q   <= mem_q[rd_ptr_q];
      s2_full_q    <= (s1_cmd_q == CMD_PUSH) && ring_full;
      s2_started_q <= (s1_cmd_q == CMD_START) && !ring_empty;
    end
  end

  // Stage 2: direction state, clock selection and the step product.
  always_comb begin
    x_dir_d    = x_dir_q;
    y_dir_d    = y_dir_q;
    z_dir_d    = z_dir_q;
    z_period_d = z_period_q;
    run_xy_d   = 1'b0;
    run_z_d    = 1'b0;
    tenths_d   = 1'b0;
    use_z_d    = 1'b0;
    if (s2_started_q) begin
      unique case (s2_entry_q.kind) inside
        KIND_LEFT: begin
          x_dir_d = 1'b0; y_dir_d = 1'b0; run_xy_d = 1'b1;
        end
        KIND_RIGHT: begin
          x_dir_d = 1'b1; y_dir_d = 1'b1; run_xy_d = 1'b1;
        end
        KIND_UP: begin
          x_dir_d = 1'b0; y_dir_d = 1'b1; run_xy_d = 1'b1;
        end
        KIND_DOWN: begin
          x_dir_d = 1'b1; y_dir_d = 1'b0; run_xy_d = 1'b1;
        end
        KIND_SUBMM_UP: begin
          x_dir_d = 1'b0; y_dir_d = 1'b1; run_xy_d = 1'b1; tenths_d = 1'b1;
        end
        KIND_SUBMM_DOWN: begin
          x_dir_d = 1'b1; y_dir_d = 1'b0; run_xy_d = 1'b1; tenths_d = 1'b1;
        end
        KIND_CW: begin
          z_dir_d = 1'b0; run_z_d = 1'b1; use_z_d = 1'b1;
        end
        KIND_ACW: begin
          z_dir_d = 1'b1; run_z_d = 1'b1; use_z_d = 1'b1;
        end
        KIND_RIGHT_CW, KIND_RIGHT_ACW: begin
          x_dir_d = 1'b1; y_dir_d = 1'b1; z_dir_d = (s2_entry_q.kind == KIND_RIGHT_ACW);
          run_xy_d = 1'b1; run_z_d = 1'b1; z_period_d = Z_PERIOD_DIAG;
        end
        KIND_LEFT_CW, KIND_LEFT_ACW: begin
          x_dir_d = 1'b0; y_dir_d = 1'b0; z_dir_d = (s2_entry_q.kind == KIND_LEFT_ACW);
          run_xy_d = 1'b1; run_z_d = 1'b1; z_period_d = Z_PERIOD_DIAG;
        end
        KIND_UP_CW, KIND_UP_ACW: begin
          x_dir_d = 1'b0; y_dir_d = 1'b1; z_dir_d = (s2_entry_q.kind == KIND_UP_ACW);
        end
        KIND_DOWN_CW, KIND_DOWN_ACW: begin
          x_dir_d = 1'b1; y_dir_d = 1'b0; z_dir_d = (s2_entry_q.kind == KIND_DOWN_ACW);
        end
        default: ;
      endcase
    end
  end

  // Kinds that run no clock leave the product at zero, which gives a zero compare value.
  assign dist_d  = use_z_d ? s2_entry_q.z_dist : s2_entry_q.xy_dist;
  assign steps_d = use_z_d ? z_steps_q : xy_steps_q;
  assign prod_d  = (run_xy_d || run_z_d) ? (16'(dist_d) * 16'(steps_d)) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_dir_q    <= 1'b0;
      y_dir_q    <= 1'b0;
      z_dir_q    <= 1'b0;
      z_period_q <= Z_PERIOD_RESET;
      s3_v_q     <= 1'b0;
    end else begin
      if (s2_v_q && adv3) begin
        x_dir_q    <= x_dir_d;
        y_dir_q    <= y_dir_d;
        z_dir_q    <= z_dir_d;
        z_period_q <= z_period_d;
      end
      if (adv3) begin
        s3_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      s3_stat_q   <= '{full: s2_full_q, started: s2_started_q, x_dir: x_dir_d,
                       y_dir: y_dir_d, z_dir: z_dir_d, run_xy: run_xy_d,
                       run_z: run_z_d, z_period: z_period_d};
      s3_prod_q   <= prod_d;
      s3_tenths_q <= tenths_d;
    end
  end

  // Stage 3: (p*31250 - 1000)/1000 reduces to (125p - 4)/4, and the sub-millimetre
  // variant, a further tenth of that, to (25p - 1)/8, both floored.
  assign x125 = {s3_prod_q, 7'b0} - {6'b0, s3_prod_q, 1'b0} - {7'b0, s3_prod_q};
  assign x25  = {1'b0, s3_prod_q, 4'b0} + {2'b0, s3_prod_q, 3'b0} + {5'b0, s3_prod_q};
  assign plain_full  = x125 - 23'd4;
  assign tenths_full = x25 - 21'd1;

  always_comb begin
    if (s3_prod_q == '0) begin
      dur = '0;
    end else if (s3_tenths_q) begin
      dur = {3'b0, tenths_full[20:3]};
    end else begin
      dur = plain_full[22:2];
    end
    sat_d = |dur[20:16];
    cmp_d = sat_d ? 16'hFFFF : dur[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv_out) begin
      out_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out) begin
      out_stat_q <= s3_stat_q;
      out_cmp_q  <= cmp_d;
      out_sat_q  <= sat_d;
    end
  end

  assign out_valid_o          = out_v_q;
  assign queue_full_o         = out_stat_q.full;
  assign started_o            = out_stat_q.started;
  assign x_direction_o        = out_stat_q.x_dir;
  assign y_direction_o        = out_stat_q.y_dir;
  assign z_direction_o        = out_stat_q.z_dir;
  assign run_xy_clocks_o      = out_stat_q.run_xy;
  assign run_z_clock_o        = out_stat_q.run_z;
  assign z_step_period_o      = out_stat_q.z_period;
  assign oneshot_compare_o    = out_cmp_q;
  assign duration_saturated_o = out_sat_q;

endmodule

@@ tb/tb_stepper_move_queue_dispatcher_core.sv @@
// Self-checking testbench for the stepper move queue dispatcher core.
`timescale 1ns / 1ps

module tb_stepper_move_queue_dispatcher_core;
  import stmqd_pkg::*;

  localparam int RING_SLOTS = 16;
  localparam int RANDOM_ITEMS_PER_PHASE = 240;
  localparam int PHASE_COUNT = 7;
  localparam int STALL_LIMIT = 4000;
  localparam int REPORT_LIMIT = 10;
  localparam int DRAIN_CYCLES = 10;

  // Indexes outside the register file; writes to them must have no effect.
  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 2'd3;

  localparam longint unsigned HALF_STEP_TICKS = 2 * 15625;
  localparam longint unsigned TICK_SCALE = 1000;
  localparam longint unsigned SUBMM_DIVISOR = 10;
  localparam longint unsigned COMPARE_MAX = 65535;

  typedef struct packed {
    logic       cmd;
    logic [3:0] kind;
    logic [7:0] xy_dist;
    logic [7:0] z_dist;
  } cmd_item_t;

  typedef struct packed {
    logic        full;
    logic        started;
    logic        x_dir;
    logic        y_dir;
    logic        z_dir;
    logic        run_xy;
    logic        run_z;
    logic [9:0]  z_period;
    logic [15:0] cmp_value;
    logic        sat;
  } dispatch_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                command_i = CMD_PUSH;
  logic [3:0]          move_kind_i = KIND_LEFT;
  logic [7:0]          xy_distance_i = '0;
  logic [7:0]          z_distance_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                queue_full_o;
  logic                started_o;
  logic                x_direction_o;
  logic                y_direction_o;
  logic                z_direction_o;
  logic                run_xy_clocks_o;
  logic                run_z_clock_o;
  logic [9:0]          z_step_period_o;
  logic [15:0]         oneshot_compare_o;
  logic                duration_saturated_o;

  stepper_move_queue_dispatcher_core #(
    .QUEUE_DEPTH(RING_SLOTS)
  ) DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .command_i           (command_i),
    .move_kind_i         (move_kind_i),
    .xy_distance_i       (xy_distance_i),
    .z_distance_i        (z_distance_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .queue_full_o        (queue_full_o),
    .started_o           (started_o),
    .x_direction_o       (x_direction_o),
    .y_direction_o       (y_direction_o),
    .z_direction_o       (z_direction_o),
    .run_xy_clocks_o     (run_xy_clocks_o),
    .run_z_clock_o       (run_z_clock_o),
    .z_step_period_o     (z_step_period_o),
    .oneshot_compare_o   (oneshot_compare_o),
    .duration_saturated_o(duration_saturated_o)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: the move ring, retained directions and step rates.
  move_t       ring_store [RING_SLOTS];
  int unsigned head_idx = 0;
  int unsigned tail_idx = 0;
  logic        dir_x = 1'b0;
  logic        dir_y = 1'b0;
  logic        dir_z = 1'b0;
  logic [9:0]  z_period_now = Z_PERIOD_RESET;
  logic [7:0]  xy_steps = XY_STEPS_RESET;
  logic [7:0]  z_steps = Z_STEPS_RESET;

  cmd_item_t        pending_items [$];
  dispatch_result_t expected_dispatches [$];
  cmd_item_t        next_item;
  dispatch_result_t want;

  int  send_idle_pct = 0;
  int  stall_pct = 0;
  logic in_fire = 1'b0;
  int  mismatch_count = 0;
  int  result_count = 0;
  int  accepted_count = 0;
  int  quiet_cycles = 0;
  int  started_count = 0;
  int  refused_count = 0;
  int  empty_start_count = 0;
  int  saturated_count = 0;

  function automatic int unsigned ring_advance(input int unsigned idx);
    return (idx + 1 >= RING_SLOTS) ? 0 : idx + 1;
  endfunction

  function automatic logic [15:0] move_duration(input logic [7:0] distance,
                                                input logic [7:0] steps,
                                                input bit tenths,
                                                output logic saturated);
    longint unsigned steps_total;
    longint unsigned ticks;
    saturated = 1'b0;
    steps_total = longint'(distance) * longint'(steps);
    if (steps_total == 0) return '0;
    ticks = (steps_total * HALF_STEP_TICKS - TICK_SCALE) / TICK_SCALE;
    if (tenths) ticks = ticks / SUBMM_DIVISOR;
    if (ticks > COMPARE_MAX) begin
      saturated = 1'b1;
      return 16'hFFFF;
    end
    return 16'(ticks);
  endfunction

  function automatic dispatch_result_t dispatch_move(input cmd_item_t item);
    dispatch_result_t res;
    move_t slot;
    res = '0;
    if (item.cmd == CMD_PUSH) begin
      if (ring_advance(tail_idx) == head_idx) begin
        res.full = 1'b1;
        refused_count++;
      end else begin
        ring_store[tail_idx] = '{item.kind, item.xy_dist, item.z_dist};
        tail_idx = ring_advance(tail_idx);
      end
    end else if (head_idx == tail_idx) begin
      empty_start_count++;
    end else begin
      slot = ring_store[head_idx];
      head_idx = ring_advance(head_idx);
      res.started = 1'b1;
      started_count++;
      case (slot.kind)
        KIND_LEFT: begin
          dir_x = 1'b0; dir_y = 1'b0;
        end
        KIND_RIGHT: begin
          dir_x = 1'b1; dir_y = 1'b1;
        end
        KIND_UP, KIND_SUBMM_UP: begin
          dir_x = 1'b0; dir_y = 1'b1;
        end
        KIND_DOWN, KIND_SUBMM_DOWN: begin
          dir_x = 1'b1; dir_y = 1'b0;
        end
        KIND_CW:        dir_z = 1'b0;
        KIND_ACW:       dir_z = 1'b1;
        KIND_RIGHT_CW: begin
          dir_x = 1'b1; dir_y = 1'b1; dir_z = 1'b0;
        end
        KIND_LEFT_CW: begin
          dir_x = 1'b0; dir_y = 1'b0; dir_z = 1'b0;
        end
        KIND_RIGHT_ACW: begin
          dir_x = 1'b1; dir_y = 1'b1; dir_z = 1'b1;
        end
        KIND_LEFT_ACW: begin
          dir_x = 1'b0; dir_y = 1'b0; dir_z = 1'b1;
        end
        KIND_UP_CW: begin
          dir_x = 1'b0; dir_y = 1'b1; dir_z = 1'b0;
        end
        KIND_DOWN_CW: begin
          dir_x = 1'b1; dir_y = 1'b0; dir_z = 1'b0;
        end
        KIND_UP_ACW: begin
          dir_x = 1'b0; dir_y = 1'b1; dir_z = 1'b1;
        end
        default: begin
          dir_x = 1'b1; dir_y = 1'b0; dir_z = 1'b1;
        end
      endcase
      // Direction-only kinds run no clock and leave the duration at zero.
      if (slot.kind <= KIND_DOWN) begin
        res.run_xy = 1'b1;
        res.cmp_value = move_duration(slot.xy_dist, xy_steps, 1'b0, res.sat);
      end else if (slot.kind <= KIND_ACW) begin
        res.run_z = 1'b1;
        res.cmp_value = move_duration(slot.z_dist, z_steps, 1'b0, res.sat);
      end else if (slot.kind <= KIND_LEFT_ACW) begin
        res.run_xy = 1'b1;
        res.run_z = 1'b1;
        z_period_now = Z_PERIOD_DIAG;
        res.cmp_value = move_duration(slot.xy_dist, xy_steps, 1'b0, res.sat);
      end else if (slot.kind >= KIND_SUBMM_DOWN) begin
        res.run_xy = 1'b1;
        res.cmp_value = move_duration(slot.xy_dist, xy_steps, 1'b1, res.sat);
      end
      if (res.sat) saturated_count++;
    end
    res.x_dir = dir_x;
    res.y_dir = dir_y;
    res.z_dir = dir_z;
    res.z_period = z_period_now;
    return res;
  endfunction

  function automatic logic [7:0] pick_distance();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return 8'd0;
    if (roll < 20) return 8'd255;
    if (roll < 45) return 8'($urandom_range(9, 1));
    return 8'($urandom_range(255));
  endfunction

  task automatic check_field(input string field, input logic [15:0] exp_val,
                             input logic [15:0] got_val);
    if (exp_val !== got_val) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
        $display("result %0d: %s expected %0d, got %0d", result_count, field,
                 exp_val, got_val);
      end
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    if (idx == CFG_XY_STEPS) xy_steps = val;
    else if (idx == CFG_Z_STEPS) z_steps = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Input driver: a new transfer is offered only once the previous one has gone.
  always @(negedge clk_i) begin
    if (!in_valid_i || in_fire) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = pending_items.pop_front();
        in_valid_i <= 1'b1;
        command_i <= next_item.cmd;
        move_kind_i <= next_item.kind;
        xy_distance_i <= next_item.xy_dist;
        z_distance_i <= next_item.z_dist;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Monitor: predicts on each input transfer and checks each output transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_fire <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        accepted_count++;
        expected_dispatches.push_back(dispatch_move(cmd_item_t'{command_i, move_kind_i,
                                                                xy_distance_i, z_distance_i}));
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_dispatches.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("result %0d arrived with nothing expected", result_count);
          end
        end else begin
          want = expected_dispatches.pop_front();
          check_field("queue_full", 16'(want.full), 16'(queue_full_o));
          check_field("started", 16'(want.started), 16'(started_o));
          check_field("x_direction", 16'(want.x_dir), 16'(x_direction_o));
          check_field("y_direction", 16'(want.y_dir), 16'(y_direction_o));
          check_field("z_direction", 16'(want.z_dir), 16'(z_direction_o));
          check_field("run_xy_clocks", 16'(want.run_xy), 16'(run_xy_clocks_o));
          check_field("run_z_clock", 16'(want.run_z), 16'(run_z_clock_o));
          check_field("z_step_period", 16'(want.z_period), 16'(z_step_period_o));
          check_field("oneshot_compare", want.cmp_value, oneshot_compare_o);
          check_field("duration_saturated", 16'(want.sat), 16'(duration_saturated_o));
        end
        result_count++;
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("no transfer for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int  added;
    int  pattern;
    int  burst;
    logic cmd;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      // Step rates are changed only once the pipeline has drained.
      case (phase)
        1: begin
          write_reg(CFG_XY_STEPS, 8'd1);
          write_reg(CFG_Z_STEPS, 8'd255);
        end
        2: begin
          write_reg(CFG_XY_STEPS, 8'd255);
          write_reg(CFG_Z_STEPS, 8'd1);
        end
        3: begin
          write_reg(CFG_XY_STEPS, 8'd0);
          write_reg(CFG_Z_STEPS, 8'd0);
          write_reg(CFG_SPARE_A, 8'hFF);
          write_reg(CFG_SPARE_B, 8'h5A);
        end
        4: begin
          write_reg(CFG_XY_STEPS, 8'($urandom_range(255, 1)));
          write_reg(CFG_Z_STEPS, 8'($urandom_range(255, 1)));
        end
        5: begin
          write_reg(CFG_XY_STEPS, 8'd255);
          write_reg(CFG_Z_STEPS, 8'd255);
        end
        6: begin
          write_reg(CFG_XY_STEPS, 8'($urandom_range(40, 1)));
          write_reg(CFG_Z_STEPS, 8'd1);
        end
        default: ;
      endcase

      case (phase % 4)
        0: begin
          send_idle_pct = 0; stall_pct = 0;
        end
        1: begin
          send_idle_pct = 72; stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0; stall_pct = 72;
        end
        default: begin
          send_idle_pct = 19; stall_pct = 19;
        end
      endcase

      if (phase == 0) begin
        // Start on an empty ring, then one of each timing source, the zero and
        // saturation corners, and a diagonal late so the reset Z period shows first.
        pending_items.push_back('{CMD_START, KIND_LEFT, 8'd0, 8'd0});
        pending_items.push_back('{CMD_PUSH, KIND_LEFT, 8'd0, 8'd255});
        pending_items.push_back('{CMD_PUSH, KIND_UP, 8'd1, 8'd0});
        pending_items.push_back('{CMD_PUSH, KIND_DOWN, 8'd255, 8'd255});
        pending_items.push_back('{CMD_PUSH, KIND_CW, 8'd0, 8'd255});
        pending_items.push_back('{CMD_PUSH, KIND_ACW, 8'd255, 8'd0});
        pending_items.push_back('{CMD_PUSH, KIND_UP_CW, 8'd200, 8'd200});
        pending_items.push_back('{CMD_PUSH, KIND_SUBMM_DOWN, 8'd1, 8'd0});
        pending_items.push_back('{CMD_PUSH, KIND_SUBMM_UP, 8'd255, 8'd0});
        pending_items.push_back('{CMD_PUSH, KIND_RIGHT_ACW, 8'd83, 8'd10});
        pending_items.push_back('{CMD_PUSH, KIND_RIGHT, 8'd84, 8'd0});
        repeat (10) pending_items.push_back('{CMD_START, KIND_LEFT, 8'd0, 8'd0});
        pending_items.push_back('{CMD_START, KIND_DOWN_ACW, 8'd255, 8'd255});
      end

      // Bursts of pushes fill the ring to refusal, bursts of starts drain it dry.
      added = 0;
      while (added < RANDOM_ITEMS_PER_PHASE) begin
        pattern = $urandom_range(99);
        burst = $urandom_range(18, 1);
        for (int k = 0; k < burst; k++) begin
          if (pattern < 35) cmd = CMD_PUSH;
          else if (pattern < 65) cmd = CMD_START;
          else cmd = 1'($urandom_range(1));
          pending_items.push_back('{cmd, 4'($urandom_range(15)), pick_distance(),
                                   pick_distance()});
        end
        added += burst;
      end

      while (pending_items.size() != 0 || in_valid_i || expected_dispatches.size() != 0) begin
        @(negedge clk_i);
      end
      repeat (DRAIN_CYCLES) @(negedge clk_i);
    end

    mismatch_count += expected_dispatches.size();
    $display("%0d moves in, %0d dispatched, %0d pushes refused on a full ring,",
             accepted_count, started_count, refused_count);
    $display("%0d starts on an empty ring, %0d clamped durations, %0d step-rate phases",
             empty_start_count, saturated_count, PHASE_COUNT);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
